FILE: sv/bol_pkg.sv
// bol_pkg: shared types and codes for the bounded ordered list
// operation codes, status codes, cell control word and chain token
// no dependencies
package bol_pkg;

  // operation codes carried in the input tuser field
  typedef enum logic [2:0] {
    FN_INS_HEAD = 3'd0,
    FN_APPEND   = 3'd1,
    FN_DELETE   = 3'd2,
    FN_POP      = 3'd3,
    FN_CONTAINS = 3'd4
  } func_t;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // control word broadcast to every cell
  typedef struct packed {
    logic        ins_head;
    logic        append;
    logic        pop;
    logic        walk_del;
    logic [31:0] value;
  } cell_ctl_t;

  // search token handed from cell to cell
  typedef struct packed {
    logic tok;
    logic found;
  } tok_t;

endpackage

FILE: sv/bol_cell.sv
// bol_cell: one list position, holds one entry and a search token stage
// depends on bol_pkg for the control word and token types
module bol_cell #(
  parameter int IDX = 0,
  parameter int CW  = 5
) (
  input  logic               clk,
  input  logic               rst_n,
  input  bol_pkg::cell_ctl_t ctl,
  input  logic [CW-1:0]      count,
  input  logic [31:0]        left_data,
  input  logic [31:0]        right_data,
  input  bol_pkg::tok_t      tok_in,
  output bol_pkg::tok_t      tok_out,
  output logic [31:0]        data_out
);

  localparam logic [CW-1:0] IDX_C = CW'(IDX);

  logic [31:0]   entry_r;
  logic [31:0]   entry_nxt;
  bol_pkg::tok_t tok_r;
  bol_pkg::tok_t tok_nxt;
  logic          in_list;
  logic          hit;
  logic          copy_right;

  // compare this entry while the token sits here
  assign in_list    = IDX_C < count;
  assign hit        = tok_in.tok && in_list && !tok_in.found && (entry_r == ctl.value);
  assign copy_right = tok_in.tok && in_list && ctl.walk_del && (tok_in.found || hit);

  always_comb begin
    tok_nxt.tok   = tok_in.tok;
    tok_nxt.found = tok_in.found || hit;
  end

  // entry update, one source per operation
  always_comb begin
    priority if (ctl.ins_head) begin
      entry_nxt = left_data;
    end else if (ctl.append && (IDX_C == count)) begin
      entry_nxt = ctl.value;
    end else if (ctl.pop || copy_right) begin
      entry_nxt = right_data;
    end else begin
      entry_nxt = entry_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
    entry_r <= entry_nxt;
  end

  assign tok_out  = tok_r;
  assign data_out = entry_r;

endmodule

FILE: sv/bounded_ordered_list_top.sv
// Bounded ordered list of signed 32-bit values, up to CAPACITY entries, head
// first. Insert head, append tail, pop head and unknown codes finish in the
// accept cycle and their result word is valid the cycle after. Delete and
// contains send a token down the chain of cells, one cell per cycle; once it
// leaves the last cell, the result is written once the result register is
// free or being drained. A new word is accepted only when no operation is in
// flight and the result register is free or being drained. Entries need no
// clearing after reset: only positions below the entry count are ever looked at.
// depends on bol_pkg and bol_cell
module bounded_ordered_list_top #(
  parameter int CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  input  logic [2:0]  in_tuser,   // [2:0] func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // [31:0] popped_value, [32] found, [34:33] status,
                                  // [39:35] count
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  typedef enum logic [1:0] {S_IDLE, S_WALK, S_FINISH} state_t;

  state_t             state_r, state_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic               del_r, del_nxt;
  logic [31:0]        value_r, value_nxt;
  logic               found_r, found_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [31:0]        out_popped_r, out_popped_nxt;
  logic               out_found_r, out_found_nxt;
  logic [1:0]         out_status_r, out_status_nxt;
  logic [4:0]         out_count_r, out_count_nxt;

  bol_pkg::func_t     fn;
  bol_pkg::cell_ctl_t ctl;
  bol_pkg::tok_t      tok_chain [CAPACITY+1];
  logic [31:0]        cell_data [CAPACITY];
  logic [CAPACITY-1:0] tok_vec;
  logic               accept;
  logic               full;
  logic               empty;
  logic               start;

  // input handshake and decode
  assign in_tready = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign accept    = in_tvalid && in_tready;
  assign fn        = bol_pkg::func_t'(in_tuser);
  assign full      = (count_r == CAP_C);
  assign empty     = (count_r == '0);
  assign start     = accept && ((fn == bol_pkg::FN_DELETE) || (fn == bol_pkg::FN_CONTAINS));

  // control word for the cells
  always_comb begin
    ctl.ins_head = accept && (fn == bol_pkg::FN_INS_HEAD) && !full;
    ctl.append   = accept && (fn == bol_pkg::FN_APPEND) && !full;
    ctl.pop      = accept && (fn == bol_pkg::FN_POP) && !empty;
    ctl.walk_del = (accept && (fn == bol_pkg::FN_DELETE)) || ((state_r == S_WALK) && del_r);
    ctl.value    = accept ? in_tdata : value_r;
  end

  assign tok_chain[0] = '{tok: start, found: 1'b0};

  // chain of cells, head at index zero
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [31:0] left_d;
    logic [31:0] right_d;
    if (i == 0) begin : g_head
      assign left_d = ctl.value;
    end else begin : g_mid_l
      assign left_d = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign right_d = cell_data[i];
    end else begin : g_mid_r
      assign right_d = cell_data[i+1];
    end
    bol_cell #(.IDX(i), .CW(CW)) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .count      (count_r),
      .left_data  (left_d),
      .right_data (right_d),
      .tok_in     (tok_chain[i]),
      .tok_out    (tok_chain[i+1]),
      .data_out   (cell_data[i])
    );
    assign tok_vec[i] = tok_chain[i+1].tok;
  end

  // sequencer and result word
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    del_nxt        = del_r;
    value_nxt      = value_r;
    found_nxt      = found_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_popped_nxt = out_popped_r;
    out_found_nxt  = out_found_r;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_WALK;
          del_nxt   = (fn == bol_pkg::FN_DELETE);
          value_nxt = in_tdata;
        end else if (accept) begin
          out_valid_nxt  = 1'b1;
          out_popped_nxt = '0;
          out_found_nxt  = 1'b0;
          out_status_nxt = bol_pkg::ST_OK;
          unique case (fn)
            bol_pkg::FN_INS_HEAD, bol_pkg::FN_APPEND: begin
              if (full) begin
                out_status_nxt = bol_pkg::ST_FULL;
              end else begin
                count_nxt = count_r + 1'b1;
              end
            end
            bol_pkg::FN_POP: begin
              if (empty) begin
                out_status_nxt = bol_pkg::ST_EMPTY;
              end else begin
                out_popped_nxt = cell_data[0];
                count_nxt      = count_r - 1'b1;
              end
            end
            default: begin
            end
          endcase
          out_count_nxt = 5'(count_nxt);
        end
      end
      S_WALK: begin
        if (tok_chain[CAPACITY].tok) begin
          found_nxt = tok_chain[CAPACITY].found;
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!out_valid_r || out_tready) begin
          if (del_r && found_r) begin
            count_nxt = count_r - 1'b1;
          end
          out_valid_nxt  = 1'b1;
          out_popped_nxt = '0;
          out_found_nxt  = found_r;
          out_status_nxt = bol_pkg::ST_OK;
          out_count_nxt  = 5'(count_nxt);
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    del_r        <= del_nxt;
    value_r      <= value_nxt;
    found_r      <= found_nxt;
    out_popped_r <= out_popped_nxt;
    out_found_r  <= out_found_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_count_r, out_status_r, out_found_r, out_popped_r};

`ifndef ASSERT_OFF
  // count never passes the capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP_C)
    else $error("entry count above capacity");

  // at most one search token in the chain
  a_tok_single: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tok_vec))
    else $error("more than one token in the cell chain");

  // no token left behind once idle
  a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (tok_vec == '0))
    else $error("token in chain while idle");

  // a refused insert reports a full list
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r == bol_pkg::ST_FULL)) |-> (out_count_r == 5'(CAPACITY)))
    else $error("full status with count below capacity");

  // a match only comes with ok status
  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_found_r) |-> (out_status_r == bol_pkg::ST_OK))
    else $error("found flag with error status");
`endif

endmodule

FILE: dv/tb_bounded_ordered_list_top.sv
// testbench for bounded_ordered_list_top: directed table plus biased random operations,
// every result word checked against its typed table row or a queue-based model of the list
// depends on bol_pkg and the bounded_ordered_list_top rtl
`timescale 1ns / 1ps

module tb_bounded_ordered_list_top;

  localparam int CAPACITY     = 16;
  localparam int N_RANDOM     = 1000;
  localparam int HOLD_START   = 600;
  localparam int HOLD_CYCLES  = 250;
  localparam int QUIET_FIRST  = 400;
  localparam int QUIET_LAST   = 549;
  localparam int N_DIRECTED   = 17;
  // func codes the block must treat as no-ops
  localparam logic [2:0] FN_UNUSED_LO = 3'd5;
  localparam logic [2:0] FN_UNUSED_HI = 3'd7;

  typedef struct packed {
    logic [31:0] popped;
    logic        found;
    logic [1:0]  status;
    logic [4:0]  count;
  } list_result_t;

  typedef struct {
    logic [2:0]   op;
    logic [31:0]  value;
    int           reps;
    bit           typed;
    list_result_t exp;
  } dir_row_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;   // [31:0] value
  logic [2:0]  in_tuser   = '0;   // [2:0] func
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;         // [31:0] popped_value, [32] found, [34:33] status,
                                  // [39:35] count

  logic [31:0]  list_model[$];
  list_result_t expected_results[$];
  logic [31:0]  value_pool[8];
  bit           quiet = 1'b0;
  int           mismatches = 0;
  dir_row_t     directed_rows[N_DIRECTED];

  bounded_ordered_list_top #(.CAPACITY(CAPACITY)) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // run limit, far above the slowest legal run
  initial begin
    #5000000;
    $display("== FAIL ==");
    $finish;
  end

  // list model: apply one operation and return the result word it yields
  function automatic list_result_t apply_list_op(input logic [2:0] op, input logic [31:0] v);
    list_result_t r;
    int hit;
    r   = '0;
    hit = -1;
    unique case (op)
      bol_pkg::FN_INS_HEAD, bol_pkg::FN_APPEND: begin
        if (list_model.size() >= CAPACITY) r.status = bol_pkg::ST_FULL;
        else if (op == bol_pkg::FN_INS_HEAD) list_model.push_front(v);
        else list_model.push_back(v);
      end
      bol_pkg::FN_DELETE, bol_pkg::FN_CONTAINS: begin
        for (int k = 0; k < list_model.size(); k++) begin
          if (list_model[k] == v) begin
            hit = k;
            break;
          end
        end
        if (hit >= 0) begin
          r.found = 1'b1;
          if (op == bol_pkg::FN_DELETE) list_model.delete(hit);
        end
      end
      bol_pkg::FN_POP: begin
        if (list_model.size() == 0) r.status = bol_pkg::ST_EMPTY;
        else r.popped = list_model.pop_front();
      end
      default: ;
    endcase
    r.count = 5'(list_model.size());
    return r;
  endfunction

  // weighted op choice; filling mode pushes the list toward full, else toward empty
  function automatic logic [2:0] pick_op(input bit filling);
    int r;
    r = $urandom_range(0, 99);
    if (r >= 95) return 3'($urandom_range(FN_UNUSED_HI, FN_UNUSED_LO));
    if (filling) begin
      if (r < 30) return bol_pkg::FN_INS_HEAD;
      if (r < 60) return bol_pkg::FN_APPEND;
      if (r < 70) return bol_pkg::FN_DELETE;
      if (r < 80) return bol_pkg::FN_POP;
    end else begin
      if (r < 10) return bol_pkg::FN_INS_HEAD;
      if (r < 20) return bol_pkg::FN_APPEND;
      if (r < 50) return bol_pkg::FN_DELETE;
      if (r < 80) return bol_pkg::FN_POP;
    end
    return bol_pkg::FN_CONTAINS;
  endfunction

  // pooled values give duplicates, searches mostly aim at live entries
  function automatic logic [31:0] pick_value(input logic [2:0] op);
    if ((op == bol_pkg::FN_DELETE || op == bol_pkg::FN_CONTAINS) &&
        list_model.size() != 0 && $urandom_range(0, 99) < 60)
      return list_model[$urandom_range(0, list_model.size() - 1)];
    if ($urandom_range(0, 99) < 40) return value_pool[3'($urandom_range(0, 7))];
    return $urandom();
  endfunction

  // offer one word, hold it until accepted, then record what it should yield
  task automatic send_word(input logic [2:0] op, input logic [31:0] v, input bit typed,
                           input list_result_t typed_exp);
    list_result_t predicted;
    @(negedge clk);
    while (!quiet && $urandom_range(0, 99) < 15) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= v;
    do @(posedge clk); while (!in_tready);
    predicted = apply_list_op(op, v);
    expected_results.push_back(typed ? typed_exp : predicted);
  endtask

  // result side: ready drops at random, plus one long hold to back up the input
  initial begin : result_sink
    int cyc;
    cyc = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      cyc++;
      if (cyc >= HOLD_START && cyc < HOLD_START + HOLD_CYCLES) out_tready <= 1'b0;
      else out_tready <= quiet || ($urandom_range(0, 99) >= 15);
    end
  end

  // compare each delivered word with the oldest expectation
  always @(posedge clk) begin
    list_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result word %h", out_tdata);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        if (out_tdata[31:0] !== want.popped) begin
          $error("popped_value mismatch: expected %0d, actual %0d",
                 $signed(want.popped), $signed(out_tdata[31:0]));
          mismatches++;
        end
        if (out_tdata[32] !== want.found) begin
          $error("found mismatch: expected %0d, actual %0d", want.found, out_tdata[32]);
          mismatches++;
        end
        if (out_tdata[34:33] !== want.status) begin
          $error("status mismatch: expected %0d, actual %0d", want.status, out_tdata[34:33]);
          mismatches++;
        end
        if (out_tdata[39:35] !== want.count) begin
          $error("count mismatch: expected %0d, actual %0d", want.count, out_tdata[39:35]);
          mismatches++;
        end
      end
    end
  end

  // main sequence: reset, directed table, random traffic, drain
  initial begin : stimulus
    bit         filling;
    int         mode_left;
    logic [2:0] op;

    // op, value, repeat, typed, {popped, found, status, count}
    directed_rows = '{
      '{bol_pkg::FN_POP,      32'h0000_0000, 1,  1'b1,
        '{32'h0000_0000, 1'b0, bol_pkg::ST_EMPTY, 5'd0}},
      '{bol_pkg::FN_DELETE,   32'h1234_5678, 1,  1'b1,
        '{32'h0000_0000, 1'b0, bol_pkg::ST_OK,    5'd0}},
      '{bol_pkg::FN_INS_HEAD, 32'h8000_0000, 1,  1'b1,
        '{32'h0000_0000, 1'b0, bol_pkg::ST_OK,    5'd1}},
      '{bol_pkg::FN_APPEND,   32'h7fff_ffff, 1,  1'b1,
        '{32'h0000_0000, 1'b0, bol_pkg::ST_OK,    5'd2}},
      '{bol_pkg::FN_CONTAINS, 32'h8000_0000, 1,  1'b1,
        '{32'h0000_0000, 1'b1, bol_pkg::ST_OK,    5'd2}},
      '{bol_pkg::FN_CONTAINS, 32'h0000_0000, 1,  1'b1,
        '{32'h0000_0000, 1'b0, bol_pkg::ST_OK,    5'd2}},
      '{FN_UNUSED_LO,         32'hffff_ffff, 1,  1'b1,
        '{32'h0000_0000, 1'b0, bol_pkg::ST_OK,    5'd2}},
      '{bol_pkg::FN_DELETE,   32'h7fff_ffff, 1,  1'b1,
        '{32'h0000_0000, 1'b1, bol_pkg::ST_OK,    5'd1}},
      '{bol_pkg::FN_POP,      32'hdead_beef, 1,  1'b1,
        '{32'h8000_0000, 1'b0, bol_pkg::ST_OK,    5'd0}},
      '{bol_pkg::FN_APPEND,   32'hffff_ffff, 1,  1'b1,
        '{32'h0000_0000, 1'b0, bol_pkg::ST_OK,    5'd1}},
      // fill to capacity with 0..14 behind the -1
      '{bol_pkg::FN_APPEND,   32'h0000_0000, 15, 1'b0,
        '{32'h0000_0000, 1'b0, bol_pkg::ST_OK,    5'd0}},
      '{bol_pkg::FN_INS_HEAD, 32'h0000_0005, 1,  1'b1,
        '{32'h0000_0000, 1'b0, bol_pkg::ST_FULL,  5'd16}},
      '{bol_pkg::FN_APPEND,   32'h0000_0006, 1,  1'b1,
        '{32'h0000_0000, 1'b0, bol_pkg::ST_FULL,  5'd16}},
      '{bol_pkg::FN_DELETE,   32'hffff_ffff, 1,  1'b1,
        '{32'h0000_0000, 1'b1, bol_pkg::ST_OK,    5'd15}},
      '{bol_pkg::FN_CONTAINS, 32'h0000_000e, 1,  1'b1,
        '{32'h0000_0000, 1'b1, bol_pkg::ST_OK,    5'd15}},
      '{bol_pkg::FN_INS_HEAD, 32'h0000_0001, 1,  1'b1,
        '{32'h0000_0000, 1'b0, bol_pkg::ST_OK,    5'd16}},
      '{bol_pkg::FN_POP,      32'h0000_0000, 1,  1'b1,
        '{32'h0000_0001, 1'b0, bol_pkg::ST_OK,    5'd15}}
    };
    value_pool = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff,
                   $urandom(), $urandom(), $urandom(), $urandom()};

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      for (int r = 0; r < directed_rows[i].reps; r++)
        send_word(directed_rows[i].op, directed_rows[i].value + 32'(r),
                  directed_rows[i].typed, directed_rows[i].exp);
    end

    // random traffic, alternating fill and drain spells so count sweeps its range
    filling   = 1'b1;
    mode_left = $urandom_range(20, 60);
    for (int n = 0; n < N_RANDOM; n++) begin
      quiet = (n >= QUIET_FIRST && n <= QUIET_LAST);
      if (mode_left == 0) begin
        filling   = !filling;
        mode_left = $urandom_range(20, 60);
      end
      mode_left--;
      if (n % 100 == 99) value_pool[3'($urandom_range(4, 7))] = $urandom();
      op = pick_op(filling);
      send_word(op, pick_value(op), 1'b0, '0);
    end
    quiet = 1'b0;
    @(negedge clk);
    in_tvalid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (3 * CAPACITY) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
